// ===== hw/rtl/imu_oc_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_oc_pkg
// Shared types and constants for the IMU offset calibration block.
// ----------------------------------------------------------------------------
package imu_oc_pkg;

    // Axis lanes: acc X, acc Y, gyro X, gyro Y, gyro Z
    localparam int NUM_LANES = 5;
    localparam int LANE_ACC_X  = 0;
    localparam int LANE_ACC_Y  = 1;
    localparam int LANE_GYRO_X = 2;
    localparam int LANE_GYRO_Y = 3;
    localparam int LANE_GYRO_Z = 4;

    // Frame kinds
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_CAL  = 1'b1;

    // Reset value of the sample count register
    localparam logic [15:0] CAL_SAMPLES_RST = 16'd1000;

    // Gyro deadband: values strictly inside (-DB_LIMIT, DB_LIMIT) become zero
    localparam logic signed [15:0] DB_LIMIT = 16'sd4;

    // Temperature: 35000 + trunc((521 + t) * 100 / 34) = base +/- trunc(|x|*50/17)
    localparam logic signed [16:0] TEMP_BIAS  = 17'sd521;
    localparam logic signed [18:0] TEMP_BASE  = 19'sd35000;
    localparam logic [20:0]        TEMP_MULT  = 21'd50;
    localparam logic [20:0]        TEMP_DIV   = 21'd17;
    // 50 * floor(2^26 / 17)
    localparam logic [27:0]        TEMP_RECIP = 28'd197379000;

    // Divider step count
    localparam int DIV_STEPS = 32;

    // Control FSM
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic        cal_add;    // add the raw sample into the running sum
        logic        div_start;  // close the run, start offset division
        logic [15:0] count;      // frames summed in this run
    } lane_ctrl_t;

endpackage

// ===== hw/rtl/imu_oc_div.sv =====
// ----------------------------------------------------------------------------
// imu_oc_div
// Radix-2 restoring divider: signed 32-bit sum by unsigned 16-bit count,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imu_oc_div
    import imu_oc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic        [15:0] divisor,
    output logic               done,
    output logic signed [15:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      dvd_reg, dvd_next;
    logic [16:0]      rem_reg, rem_next;
    logic [15:0]      dsr_reg, dsr_next;
    logic             neg_reg, neg_next;

    logic [16:0] rem_sh;
    logic        q_bit;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    // One restoring step per cycle
    always_comb
    begin
        rem_sh    = {rem_reg[15:0], dvd_reg[31]};
        q_bit     = (rem_sh >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend[31] ? 32'(-dividend) : 32'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[31];
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[30:0], q_bit};
            rem_next = q_bit ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(dvd_reg[15:0]) : $signed(dvd_reg[15:0]);

endmodule

// ===== hw/rtl/imu_oc_lane.sv =====
// ----------------------------------------------------------------------------
// imu_oc_lane
// One calibrated axis: running sum, offset register, offset divider and
// offset removal with 16-bit wraparound.
// ----------------------------------------------------------------------------
module imu_oc_lane
    import imu_oc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic signed [15:0] raw,
    output logic signed [15:0] diff,
    output logic               div_done
);

    logic signed [31:0] sum_reg, sum_next;
    logic signed [15:0] offset_reg, offset_next;
    logic signed [31:0] sum_add;
    logic signed [15:0] quot;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

    // Accumulate, clear at the end of a run, take the new offset
    always_comb
    begin
        sum_add     = sum_reg + 32'(raw);
        sum_next    = sum_reg;
        offset_next = offset_reg;
        if (ctrl.div_start)
        begin
            sum_next = '0;
        end
        else if (ctrl.cal_add)
        begin
            sum_next = sum_add;
        end
        if (div_done)
        begin
            offset_next = quot;
        end
    end

    imu_oc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (sum_add),
        .divisor  (ctrl.count),
        .done     (div_done),
        .quotient (quot)
    );

    // Offset removal, wraps
    assign diff = raw - offset_reg;

endmodule

// ===== hw/rtl/imu_oc_temp.sv =====
// ----------------------------------------------------------------------------
// imu_oc_temp
// Temperature to millidegrees: reciprocal multiply, then one correction step.
// ----------------------------------------------------------------------------
module imu_oc_temp
    import imu_oc_pkg::*;
(
    input  logic               clk,
    input  logic signed [15:0] temp_raw,
    output logic signed [18:0] temp_milli
);

    logic signed [16:0] x;
    logic        [16:0] x_abs;
    logic        [43:0] prod;

    logic [15:0] mag_reg;
    logic [16:0] q0_reg;
    logic        neg_reg;

    logic [20:0]        mag50;
    logic [20:0]        q17;
    logic [20:0]        rem;
    logic [16:0]        q;
    logic signed [18:0] q_s;

    // Stage 1: bias, magnitude, estimate quotient of |x| * 50 / 17
    always_comb
    begin
        x     = 17'(temp_raw) + TEMP_BIAS;
        x_abs = x[16] ? 17'(-x) : 17'(x);
        prod  = 44'(x_abs[15:0]) * 44'(TEMP_RECIP);
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= x_abs[15:0];
        q0_reg  <= prod[42:26];
        neg_reg <= x[16];
    end

    // Stage 2: estimate is exact or one low; fix, restore sign, add base
    always_comb
    begin
        mag50 = 21'(mag_reg) * TEMP_MULT;
        q17   = 21'(q0_reg) * TEMP_DIV;
        rem   = mag50 - q17;
        q     = q0_reg + 17'(rem >= TEMP_DIV);
        q_s   = $signed({2'b00, q});
        temp_milli = TEMP_BASE + (neg_reg ? -q_s : q_s);
    end

endmodule

// ===== hw/rtl/imu_offset_calibrate_deadband_top.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibrate_deadband_top
// IMU bias calibration: running sums, offset averaging, offset removal,
// gyro deadband and temperature conversion for one sensor frame per transfer.
// ----------------------------------------------------------------------------
// Flow: a frame is held in frame_reg and passes through ST_MUL and ST_OUT;
// a calibration frame that closes a run also waits in ST_DIV for the 32-step
// offset dividers. Input is taken only in ST_IDLE, so frames go one at a
// time; the next frame is taken while a result waits in the output register.
// Reset: asynchronous, active low; clears offsets, sums, run progress, last
// temperature and sets cal_samples to 1000.
module imu_offset_calibrate_deadband_top
    import imu_oc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,     // cal_samples
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // acc_x_raw, acc_y_raw, acc_z_raw, temp_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tuser,    // kind
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, temp_milli, 5 zero bits
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tuser     // cal_done
);

    state_t state_reg, state_next;

    logic [15:0] cal_samples_reg;
    logic [15:0] progress_reg, progress_next;
    logic        done_reg, done_next;
    logic signed [18:0] last_temp_reg, last_temp_next;

    logic [111:0] frame_reg;
    logic         kind_reg;

    logic         out_valid_reg, out_valid_next;
    logic [119:0] out_data_reg;
    logic         out_user_reg;

    logic         in_xfer;
    logic         out_load;
    logic [15:0]  target;
    logic [15:0]  progress_inc;
    lane_ctrl_t   lane_ctrl;

    logic signed [15:0] lane_raw  [NUM_LANES];
    logic signed [15:0] lane_diff [NUM_LANES];
    logic [NUM_LANES-1:0] lane_done;

    logic signed [15:0] acc_z_raw;
    logic signed [15:0] temp_raw;
    logic signed [18:0] temp_conv;
    logic signed [15:0] res [NUM_LANES];
    logic signed [18:0] res_temp;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // Field split of the held frame
    assign lane_raw[LANE_ACC_X]  = $signed(frame_reg[15:0]);
    assign lane_raw[LANE_ACC_Y]  = $signed(frame_reg[31:16]);
    assign acc_z_raw             = $signed(frame_reg[47:32]);
    assign temp_raw              = $signed(frame_reg[63:48]);
    assign lane_raw[LANE_GYRO_X] = $signed(frame_reg[79:64]);
    assign lane_raw[LANE_GYRO_Y] = $signed(frame_reg[95:80]);
    assign lane_raw[LANE_GYRO_Z] = $signed(frame_reg[111:96]);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= CAL_SAMPLES_RST;
        end
        else if (cfg_wr_en)
        begin
            cal_samples_reg <= cfg_wr_data;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            progress_reg  <= '0;
            done_reg      <= 1'b0;
            last_temp_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            progress_reg  <= progress_next;
            done_reg      <= done_next;
            last_temp_reg <= last_temp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            frame_reg <= s_axis_tdata;
            kind_reg  <= s_axis_tuser;
        end
        if (out_load)
        begin
            out_data_reg <= {5'b0, res_temp, res[LANE_GYRO_Z], res[LANE_GYRO_Y],
                             res[LANE_GYRO_X], acc_z_raw, res[LANE_ACC_Y],
                             res[LANE_ACC_X]};
            out_user_reg <= done_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        target         = (cal_samples_reg == '0) ? 16'd1 : cal_samples_reg;
        progress_inc   = progress_reg + 16'd1;
        state_next     = state_reg;
        progress_next  = progress_reg;
        done_next      = done_reg;
        last_temp_next = last_temp_reg;
        lane_ctrl      = '{cal_add: 1'b0, div_start: 1'b0, count: progress_inc};
        s_axis_tready  = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                done_next  = 1'b0;
                state_next = ST_OUT;
                if (kind_reg == KIND_CAL)
                begin
                    lane_ctrl.cal_add = 1'b1;
                    if (progress_inc >= target)
                    begin
                        lane_ctrl.div_start = 1'b1;
                        progress_next       = '0;
                        done_next           = 1'b1;
                        state_next          = ST_DIV;
                    end
                    else
                    begin
                        progress_next = progress_inc;
                    end
                end
            end
            ST_DIV:
            begin
                if (&lane_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (kind_reg == KIND_MEAS)
                    begin
                        last_temp_next = temp_conv;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Axis lanes
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        imu_oc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .raw      (lane_raw[i]),
            .diff     (lane_diff[i]),
            .div_done (lane_done[i])
        );
    end

    // Temperature conversion
    imu_oc_temp u_temp (
        .clk        (clk),
        .temp_raw   (temp_raw),
        .temp_milli (temp_conv)
    );

    // Merge: raw pass-through on calibration, else offset removal and gyro deadband
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (kind_reg == KIND_CAL)
            begin
                res[i] = lane_raw[i];
            end
            else if (i >= LANE_GYRO_X && lane_diff[i] > -DB_LIMIT && lane_diff[i] < DB_LIMIT)
            begin
                res[i] = '0;
            end
            else
            begin
                res[i] = lane_diff[i];
            end
        end
        res_temp = (kind_reg == KIND_CAL) ? last_temp_reg : temp_conv;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== hw/rtl/imu_oc_checker.sv =====
// ----------------------------------------------------------------------------
// imu_oc_checker
// Port-level checks for the IMU offset calibration block, bound to the top.
// ----------------------------------------------------------------------------
module imu_oc_checker
    import imu_oc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // One frame at a time: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // Result stays offered until taken
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output valid dropped without transfer");

    // Stalled result holds its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output payload changed while stalled");

    // Temperature stays within the reachable millidegree range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[114:96]) >= -19'sd59844 &&
                           $signed(m_axis_tdata[114:96]) <= 19'sd132905))
        else $error("temperature out of range");

endmodule

bind imu_offset_calibrate_deadband_top imu_oc_checker u_checker (.*);
